FILE: hdl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and constants for the frame deframer: result kinds, the
// queue entry passed from the parser to the output stage, header constants.
// ----------------------------------------------------------------------------
package wsd_pkg;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_UNMASKED = 3'd2,
    KIND_BADOP    = 3'd3,
    KIND_TOOLONG  = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] raw;
    logic [7:0] key;
    logic       last;
    logic       pong;
  } q_entry_t;

  localparam logic [31:0] MAX_LEN_RESET = 32'd65536;
  localparam logic [3:0]  OPC_TEXT      = 4'h1;
  localparam logic [3:0]  OPC_PING      = 4'h9;
  localparam logic [6:0]  LEN7_MAX      = 7'd125;
  localparam logic [6:0]  LEN7_EXT16    = 7'd126;
  localparam logic [3:0]  EXT16_BYTES   = 4'd2;
  localparam logic [3:0]  EXT64_BYTES   = 4'd8;
  localparam logic [3:0]  MASK_BYTES    = 4'd4;

endpackage

FILE: hdl/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Header parser: tracks the frame phase, gathers length and mask key, checks
// errors and pushes one queue entry per beat that yields a result.
// ----------------------------------------------------------------------------
module wsd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_restart,
  input  logic              cfg_valid,
  input  logic [31:0]       cfg_data,
  input  logic              q_full,
  output logic              q_push,
  output wsd_pkg::q_entry_t q_entry
);

  typedef enum logic [5:0] {
    PH_HDR0    = 6'b000001,
    PH_HDR1    = 6'b000010,
    PH_EXT16   = 6'b000100,
    PH_EXT64   = 6'b001000,
    PH_MASK    = 6'b010000,
    PH_PAYLOAD = 6'b100000
  } phase_t;

  phase_t      phase_r, phase_nxt, ph_eff;
  logic [3:0]  cnt_r, cnt_nxt, cnt_inc, need;
  logic [63:0] len_r, len_nxt, len_shift;
  logic [31:0] rem_r, rem_nxt, rem_dec;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [3:0]  opc_r, opc_nxt;
  logic        ping_r, ping_nxt;
  logic        err_r, err_nxt, err_eff;
  logic [31:0] max_r;
  logic        accept;
  logic [6:0]  len7;
  logic        ext_long, len7_long;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cnt_inc   = cnt_r + 4'd1;
  assign need      = (phase_r == PH_EXT16) ? wsd_pkg::EXT16_BYTES : wsd_pkg::EXT64_BYTES;
  assign len_shift = {len_r[55:0], in_byte};
  assign ext_long  = (|len_shift[63:32]) || (len_shift[31:0] > max_r);
  assign len7      = in_byte[6:0];
  assign len7_long = {25'd0, len7} > max_r;
  assign rem_dec   = (rem_r != 32'd0) ? rem_r - 32'd1 : 32'd0;
  assign err_eff   = err_r && !in_restart;
  assign ph_eff    = in_restart ? PH_HDR0 : phase_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    key_nxt   = key_r;
    idx_nxt   = idx_r;
    opc_nxt   = opc_r;
    ping_nxt  = ping_r;
    err_nxt   = err_r;
    q_push    = 1'b0;
    q_entry   = '0;
    if (accept) begin
      err_nxt   = err_eff;
      phase_nxt = ph_eff;
      if (!err_eff) begin
        case (ph_eff)
          PH_HDR0: begin
            opc_nxt   = in_byte[3:0];
            phase_nxt = PH_HDR1;
          end
          PH_HDR1: begin
            if (!in_byte[7]) begin
              err_nxt       = 1'b1;
              phase_nxt     = PH_HDR0;
              q_push        = 1'b1;
              q_entry.kind  = wsd_pkg::KIND_UNMASKED;
            end else if (opc_r != wsd_pkg::OPC_TEXT && opc_r != wsd_pkg::OPC_PING) begin
              err_nxt       = 1'b1;
              phase_nxt     = PH_HDR0;
              q_push        = 1'b1;
              q_entry.kind  = wsd_pkg::KIND_BADOP;
            end else begin
              ping_nxt = (opc_r == wsd_pkg::OPC_PING);
              cnt_nxt  = 4'd0;
              len_nxt  = 64'd0;
              if (len7 <= wsd_pkg::LEN7_MAX) begin
                if (len7_long) begin
                  err_nxt      = 1'b1;
                  phase_nxt    = PH_HDR0;
                  q_push       = 1'b1;
                  q_entry.kind = wsd_pkg::KIND_TOOLONG;
                end else begin
                  rem_nxt   = {25'd0, len7};
                  key_nxt   = 32'd0;
                  phase_nxt = PH_MASK;
                end
              end else begin
                phase_nxt = (len7 == wsd_pkg::LEN7_EXT16) ? PH_EXT16 : PH_EXT64;
              end
            end
          end
          PH_EXT16, PH_EXT64: begin
            len_nxt = len_shift;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= need) begin
              if (ext_long) begin
                err_nxt      = 1'b1;
                phase_nxt    = PH_HDR0;
                q_push       = 1'b1;
                q_entry.kind = wsd_pkg::KIND_TOOLONG;
              end else begin
                rem_nxt   = len_shift[31:0];
                cnt_nxt   = 4'd0;
                key_nxt   = 32'd0;
                phase_nxt = PH_MASK;
              end
            end
          end
          PH_MASK: begin
            key_nxt[{cnt_r[1:0], 3'b000} +: 8] = key_r[{cnt_r[1:0], 3'b000} +: 8] | in_byte;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= wsd_pkg::MASK_BYTES) begin
              cnt_nxt = 4'd0;
              idx_nxt = 2'd0;
              if (rem_r == 32'd0) begin
                phase_nxt    = PH_HDR0;
                q_push       = 1'b1;
                q_entry.kind = wsd_pkg::KIND_EMPTY;
                q_entry.last = 1'b1;
                q_entry.pong = ping_r;
              end else begin
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            idx_nxt      = idx_r + 2'd1;
            rem_nxt      = rem_dec;
            q_push       = 1'b1;
            q_entry.kind = wsd_pkg::KIND_DATA;
            q_entry.raw  = in_byte;
            q_entry.key  = key_r[{idx_r, 3'b000} +: 8];
            q_entry.last = (rem_dec == 32'd0);
            q_entry.pong = ping_r;
            if (rem_dec == 32'd0) begin
              phase_nxt = PH_HDR0;
            end
          end
          default: begin
            phase_nxt = PH_HDR0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= 4'd0;
      len_r   <= 64'd0;
      rem_r   <= 32'd0;
      key_r   <= 32'd0;
      idx_r   <= 2'd0;
      opc_r   <= 4'd0;
      ping_r  <= 1'b0;
      err_r   <= 1'b0;
      max_r   <= wsd_pkg::MAX_LEN_RESET;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      key_r   <= key_nxt;
      idx_r   <= idx_nxt;
      opc_r   <= opc_nxt;
      ping_r  <= ping_nxt;
      err_r   <= err_nxt;
      if (cfg_valid) begin
        max_r <= cfg_data;
      end
    end
  end

endmodule

FILE: hdl/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// Short first-in first-out queue of parsed entries between parser and
// output stage.
// ----------------------------------------------------------------------------
module wsd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wsd_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              pop_valid,
  output wsd_pkg::q_entry_t pop_entry
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  wsd_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  assign full      = (cnt_r == CNT_FULL);
  assign pop_valid = (cnt_r != '0);
  assign pop_entry = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PTR_LAST) ? '0 : wr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PTR_LAST) ? '0 : rd_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_entry;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("queue count beyond depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid)
    else $error("pop from empty queue");

endmodule

FILE: hdl/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Output stage: unmasks payload bytes and holds the result beat in a
// register until the sink takes it.
// ----------------------------------------------------------------------------
module wsd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  wsd_pkg::q_entry_t q_entry,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output wsd_pkg::kind_t    out_kind,
  output logic [7:0]        out_data,
  output logic              out_last,
  output logic              out_pong
);

  logic           valid_r, valid_nxt;
  wsd_pkg::kind_t kind_r;
  logic [7:0]     data_r;
  logic           last_r, pong_r;

  assign q_pop = q_valid && (!valid_r || out_ready);

  always_comb begin
    valid_nxt = valid_r;
    if (q_pop) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      kind_r <= q_entry.kind;
      data_r <= (q_entry.kind == wsd_pkg::KIND_DATA) ? (q_entry.raw ^ q_entry.key) : 8'd0;
      last_r <= q_entry.last;
      pong_r <= q_entry.pong;
    end
  end

  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_last  = last_r;
  assign out_pong  = pong_r;

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (kind_r == wsd_pkg::KIND_UNMASKED || kind_r == wsd_pkg::KIND_BADOP
      || kind_r == wsd_pkg::KIND_TOOLONG) |-> data_r == 8'd0 && !last_r && !pong_r)
    else $error("error beat carries payload fields");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && kind_r == wsd_pkg::KIND_EMPTY |-> last_r && data_r == 8'd0)
    else $error("empty message beat not marked last");

endmodule

FILE: hdl/websocket_frame_deframer.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// Receive-side frame parser: header, length and mask key decode, payload
// unmasking, error reporting.
//
//   channel | direction | tdata / data        | side bits
//   in_     | sink      | [7:0] rx_byte       | tuser[0] restart
//   out_    | source    | [7:0] data_byte     | tuser[2:0] kind, [3] pong_needed;
//           |           |                     | tlast last_of_message
//   cfg_    | sink      | [31:0] max length   | -
//
// One input beat per cycle while the queue is not full; the parser decides
// each beat in the cycle it is accepted. A result passes through the queue
// and then the output register before it appears on out_.
// in_tready drops only when the queue is full, i.e. the sink has stalled.
// Synchronous active-low reset; max length resets to 65536, cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] restart
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_byte
  output logic [3:0]  out_tuser,  // [2:0] kind, [3] pong_needed
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic              q_full, q_push, q_pop, q_valid;
  wsd_pkg::q_entry_t push_entry, pop_entry;
  wsd_pkg::kind_t    kind;
  logic              pong;

  assign cfg_ready = 1'b1;

  wsd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_restart (in_tuser[0]),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (push_entry)
  );

  wsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  wsd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_entry   (pop_entry),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_data  (out_tdata),
    .out_last  (out_tlast),
    .out_pong  (pong)
  );

  assign out_tuser = {pong, kind};

endmodule
